// ===== design/ctrk_pkg.sv =====
`timescale 1ns / 1ps

package ctrk_pkg;

  // default stack depth
  localparam int unsigned MaxDepthDefault = 32;

  // field widths
  localparam int unsigned KindW  = 3;
  localparam int unsigned ErrW   = 3;
  localparam int unsigned DepthW = 6;

  // request kinds, codes five to seven behave as ordinary lines
  localparam logic [KindW-1:0] KIND_EXPR_IF = 3'd0;
  localparam logic [KindW-1:0] KIND_SYM_IF  = 3'd1;
  localparam logic [KindW-1:0] KIND_ELSE    = 3'd2;
  localparam logic [KindW-1:0] KIND_ENDIF   = 3'd3;
  localparam logic [KindW-1:0] KIND_LINE    = 3'd4;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE       = 3'd0,
    ERR_ENDIF_LONE = 3'd1,
    ERR_ELSE_LONE  = 3'd2,
    ERR_ELSE_DUP   = 3'd3,
    ERR_OPERAND    = 3'd4,
    ERR_OVERFLOW   = 3'd5
  } err_e;

  typedef struct packed {
    logic has_else;
    logic dead;
    logic ignoring;
  } frame_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

endpackage

// ===== design/ctrk_if.sv =====
`timescale 1ns / 1ps

interface ctrk_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic       cond_true;
  logic       negate;
  logic       operand_ok;

  modport source (output valid, req_type, cond_true, negate, operand_ok, input ready);
  modport sink (input valid, req_type, cond_true, negate, operand_ok, output ready);
endinterface

interface ctrk_rsp_if;
  logic       valid;
  logic       ready;
  logic       ignore_line;
  logic [2:0] error_code;
  logic [5:0] nest_depth;

  modport source (output valid, ignore_line, error_code, nest_depth, input ready);
  modport sink (input valid, ignore_line, error_code, nest_depth, output ready);
endinterface

// ===== design/conditional_nesting_tracker_top.sv =====
`timescale 1ns / 1ps

// conditional nesting tracker
// req_i carries one transaction per source line: an expression if, a symbol
// if, an else, an endif or an ordinary line, with the condition, negate and
// operand-valid flags. rsp_o returns exactly one transaction per request: the
// ignore flag (ordinary lines only), an error code and the nesting depth after
// the request.
// the frame stack lives in a synchronous ram of MAX_DEPTH entries with one
// read port and one write port. the top entry is read in the cycle a request
// is accepted and modified or pushed in the following execute cycle; the
// response is registered when that execute cycle completes. a new request
// is accepted only once the previous one has executed, because of the
// read-modify-write of the stack ram.
// the response sits in an output register, so a new request is accepted while
// an earlier response still waits. when the receiver stalls, the execute cycle
// holds (no ram write, no depth change) until the output register frees up.
// reset empties the stack by clearing the depth counter; the ram itself is not
// cleared since only entries below the depth are ever used.
module conditional_nesting_tracker_top #(
  parameter int unsigned MAX_DEPTH = ctrk_pkg::MaxDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ctrk_req_if.sink   req_i,
  ctrk_rsp_if.source rsp_o
);
  import ctrk_pkg::*;

  localparam int unsigned CntW  = $clog2(MAX_DEPTH + 1);
  localparam int unsigned AddrW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  // control
  state_e           state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  // captured request
  logic [KindW-1:0] kind_q;
  logic             cond_q, neg_q, ok_q;

  // response payload
  logic             ignore_q, ignore_d;
  err_e             err_q, err_d;
  logic [DepthW-1:0] depth_q;

  // stack ram
  frame_t           mem [MAX_DEPTH];
  frame_t           rd_q;
  logic [AddrW-1:0] rd_addr;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  frame_t           wr_data;

  logic             accept;
  logic             done;
  logic             empty;
  logic             full;
  logic             top_ign;

  assign accept = req_i.valid && req_i.ready;
  assign empty  = (cnt_q == '0);
  assign full   = (cnt_q == CntW'(MAX_DEPTH));
  // top entry address, only meaningful when the stack is not empty
  assign rd_addr = AddrW'(cnt_q - CntW'(1));
  assign top_ign = !empty && rd_q.ignoring;

  assign req_i.ready = (state_q == ST_IDLE);

  // the ram port runs every cycle on the current top, so read data follows
  // the depth in the next cycle; the idle cycle covers that latency
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // request capture, payload needs no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= req_i.req_type;
      cond_q <= req_i.cond_true;
      neg_q  <= req_i.negate;
      ok_q   <= req_i.operand_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      ignore_q <= ignore_d;
      err_q    <= err_d;
      depth_q  <= DepthW'(cnt_d);
    end
  end

  // execute: decode the request against the top frame
  always_comb begin
    frame_t push_f;
    frame_t else_f;

    push_f.has_else = 1'b0;
    push_f.dead     = top_ign;
    push_f.ignoring = top_ign | ~(cond_q ^ neg_q);

    else_f          = rd_q;
    else_f.ignoring = rd_q.ignoring ^ ~rd_q.dead;
    else_f.has_else = 1'b1;

    state_d     = state_q;
    cnt_d       = cnt_q;
    ignore_d    = 1'b0;
    err_d       = ERR_NONE;
    wr_en       = 1'b0;
    wr_addr     = rd_addr;
    wr_data     = push_f;
    done        = 1'b0;
    out_valid_d = out_valid_q && !rsp_o.ready;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold here while the previous response still blocks the output
        if (!out_valid_q || rsp_o.ready) begin
          done        = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          unique case (kind_q)
            KIND_EXPR_IF: begin
              if (full) begin
                err_d = ERR_OVERFLOW;
              end else begin
                // a bad expression still opens a frame
                wr_en   = 1'b1;
                wr_addr = AddrW'(cnt_q);
                cnt_d   = cnt_q + CntW'(1);
                err_d   = ok_q ? ERR_NONE : ERR_OPERAND;
              end
            end
            KIND_SYM_IF: begin
              if (!ok_q) begin
                err_d = ERR_OPERAND;
              end else if (full) begin
                err_d = ERR_OVERFLOW;
              end else begin
                wr_en   = 1'b1;
                wr_addr = AddrW'(cnt_q);
                cnt_d   = cnt_q + CntW'(1);
              end
            end
            KIND_ELSE: begin
              if (empty) begin
                err_d = ERR_ELSE_LONE;
              end else if (rd_q.has_else) begin
                err_d = ERR_ELSE_DUP;
              end else begin
                // dead frames keep ignoring, live frames flip
                wr_en   = 1'b1;
                wr_data = else_f;
              end
            end
            KIND_ENDIF: begin
              if (empty) begin
                err_d = ERR_ENDIF_LONE;
              end else begin
                cnt_d = cnt_q - CntW'(1);
              end
            end
            default: begin
              // ordinary lines and unused kinds
              ignore_d = top_ign;
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.ignore_line = ignore_q;
  assign rsp_o.error_code  = err_q;
  assign rsp_o.nest_depth  = depth_q;

  // depth never passes the stack size
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(MAX_DEPTH))
    else $error("stack depth beyond capacity");

  // a pending response always reports the live depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> depth_q == DepthW'(cnt_q))
    else $error("response depth out of step with stack");

  // the depth only moves when an execute cycle completes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(cnt_q) |-> $past(state_q == ST_EXEC && done))
    else $error("depth changed outside execute");

  // a response only appears after an execute cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EXEC))
    else $error("response without execute");

endmodule
